@@ src/xyzs_pkg.sv @@
// Shared types, constants and the gamma ROM for the XYZ to sRGB converter.
// Depends on nothing; every other file in src uses it by scoped names.
package xyzs_pkg;

	// Port and datapath widths
	localparam int IN_W      = 24;
	localparam int FRAC_BITS = 16;
	localparam int OUT_BITS  = 12;
	localparam int COEF_W    = 19;
	localparam int PROD_W    = IN_W + COEF_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int LIN_SHIFT = FRAC_BITS - 8;
	localparam int LIN_W     = 24;
	localparam int ONE_Q24   = 1 << LIN_W;
	localparam int MAXC      = (1 << OUT_BITS) - 1;

	// Gamma ROM geometry; the depth is a power of two
	localparam int GAMMA_TABLE_DEPTH = 256;
	localparam int IDX_BITS = $clog2(GAMMA_TABLE_DEPTH);
	localparam int ROM_W    = 26;
	localparam int DIFF_W   = 25;
	localparam int V_W      = ROM_W + 1;
	localparam int VC_W     = LIN_W + 1;

	// Linear segment: v = (lin*1292 + 50) / 100
	localparam int LIN_THRESH = 52526;
	localparam int LIN_GAIN   = 1292;
	localparam int LIN_ROUND  = 50;
	localparam int LIN_DEN    = 100;
	localparam int NUM_W      = $clog2(LIN_THRESH * LIN_GAIN + LIN_ROUND + 1);
	localparam int DIV_SHIFT  = NUM_W + $clog2(LIN_DEN);
	localparam longint unsigned DIV_MUL =
		((longint'(1) << DIV_SHIFT) + LIN_DEN - 1) / LIN_DEN;
	localparam int MUL_W = $clog2(DIV_MUL + 1);
	localparam int QP_W  = NUM_W + MUL_W;
	localparam int Q_W   = QP_W - DIV_SHIFT;

	// Power segment curve: 1.055*a^(5/12) - 0.055, in thousandths
	localparam int POW_GAIN   = 1055;
	localparam int POW_OFFSET = 55;
	localparam int POW_HALF   = 500;
	localparam int POW_DEN    = 1000;
	localparam int BIG_W      = 360;
	localparam int ROOT_SHIFT = 288;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t coef_row_t [3];
	typedef coef_row_t coef_mat_t [3];

	// XYZ to linear RGB, Q16
	localparam coef_mat_t COEF = '{
		'{coef_t'(212376), coef_t'(-100742), coef_t'(-32676)},
		'{coef_t'(-63498), coef_t'(122932),  coef_t'(2720)},
		'{coef_t'(3650),   coef_t'(-13369),  coef_t'(69272)}
	};

	typedef enum logic [1:0] {
		SEG_ZERO,
		SEG_SAT,
		SEG_LIN,
		SEG_POW
	} seg_t;

	typedef struct packed {
		logic adv_s3;
		logic adv_s4;
		logic adv_s5;
		logic adv_s6;
	} pipe_ctl_t;

	typedef logic signed [ROM_W-1:0] gamma_rom_t [0:GAMMA_TABLE_DEPTH];

	// Entry i: R = largest integer with R^12 * D^5 <= i^5 * 2^288,
	// then floor((1055*R - 55*2^24 + 500) / 1000). Evaluated at elaboration.
	function automatic gamma_rom_t build_gamma_rom();
		gamma_rom_t rom;
		logic [BIG_W-1:0] rhs;
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] r2;
		logic [BIG_W-1:0] r4;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint num;
		for (int i = 0; i <= GAMMA_TABLE_DEPTH; i++) begin
			rhs = BIG_W'(i);
			for (int k = 0; k < 4; k++) begin
				rhs = rhs * BIG_W'(i);
			end
			rhs = rhs << ROOT_SHIFT;
			lo = 0;
			hi = ONE_Q24;
			while (lo < hi) begin
				mid = lo + ((hi - lo + 1) >> 1);
				r2  = BIG_W'(mid) * BIG_W'(mid);
				r4  = r2 * r2;
				lhs = r4 * r4 * r4;
				for (int k = 0; k < 5; k++) begin
					lhs = lhs * BIG_W'(GAMMA_TABLE_DEPTH);
				end
				if (lhs <= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 1;
				end
			end
			num = longint'(POW_GAIN) * longint'(lo)
				- longint'(POW_OFFSET) * longint'(ONE_Q24) + longint'(POW_HALF);
			if (num >= 0) begin
				rom[i] = ROM_W'(num / POW_DEN);
			end else begin
				rom[i] = ROM_W'(-((-num + POW_DEN - 1) / POW_DEN));
			end
		end
		return rom;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma_rom();

endpackage

@@ src/xyzs_if.sv @@
// Valid/ready channel interfaces for the XYZ input beat and the RGB result beat.
// Depends on xyzs_pkg for field widths.
interface xyzs_xyz_if;
	logic valid;
	logic ready;
	logic signed [xyzs_pkg::IN_W-1:0] cie_x;
	logic signed [xyzs_pkg::IN_W-1:0] cie_y;
	logic signed [xyzs_pkg::IN_W-1:0] cie_z;

	modport source (output valid, output cie_x, output cie_y, output cie_z, input ready);
	modport sink (input valid, input cie_x, input cie_y, input cie_z, output ready);
endinterface

interface xyzs_rgb_if;
	logic valid;
	logic ready;
	logic [xyzs_pkg::OUT_BITS-1:0] red;
	logic [xyzs_pkg::OUT_BITS-1:0] green;
	logic [xyzs_pkg::OUT_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

@@ src/xyzs_encode.sv @@
// One channel of the sRGB transfer curve: stages s3 to s6 of the pipeline.
// Depends on xyzs_pkg (gamma ROM, segment codes, stage advance struct).
module xyzs_encode (
	input  logic                          clk,
	input  xyzs_pkg::pipe_ctl_t           ctl,
	input  xyzs_pkg::seg_t                seg,
	input  logic [xyzs_pkg::LIN_W-1:0]    lin,
	output logic [xyzs_pkg::OUT_BITS-1:0] code
);

	localparam int CP_W = xyzs_pkg::VC_W + xyzs_pkg::OUT_BITS;
	localparam int IP_W = xyzs_pkg::DIFF_W + xyzs_pkg::LIN_W;

	logic [xyzs_pkg::IDX_BITS-1:0]   idx;
	logic [xyzs_pkg::IDX_BITS:0]     idx_nx;
	logic signed [xyzs_pkg::ROM_W:0] diff_raw;
	logic [xyzs_pkg::NUM_W-1:0]      lin_num;
	logic [xyzs_pkg::QP_W-1:0]       qprod;
	logic [IP_W-1:0]                 iprod;
	logic signed [xyzs_pkg::V_W-1:0] v_pow;
	logic signed [xyzs_pkg::V_W-1:0] v_sel;
	logic [xyzs_pkg::VC_W-1:0]       vc;
	logic [CP_W-1:0]                 cprod;

	xyzs_pkg::seg_t                   seg_s3, seg_s4, seg_s5;
	logic [xyzs_pkg::NUM_W-1:0]       lin_num_s3;
	logic signed [xyzs_pkg::ROM_W-1:0] e0_s3, e0_s4;
	logic [xyzs_pkg::DIFF_W-1:0]      diff_s3;
	logic [xyzs_pkg::LIN_W-1:0]       t_s3;
	logic [xyzs_pkg::Q_W-1:0]         q_s4;
	logic [xyzs_pkg::DIFF_W-1:0]      interp_s4;
	logic [xyzs_pkg::VC_W-1:0]        vc_s5;
	logic [xyzs_pkg::OUT_BITS-1:0]    code_s6;

	// s3: table reads and the linear-segment numerator
	assign idx      = lin[xyzs_pkg::LIN_W-1 -: xyzs_pkg::IDX_BITS];
	assign idx_nx   = {1'b0, idx} + 1'b1;
	assign diff_raw = (xyzs_pkg::ROM_W + 1)'(xyzs_pkg::GAMMA_ROM[idx_nx])
		- (xyzs_pkg::ROM_W + 1)'(xyzs_pkg::GAMMA_ROM[{1'b0, idx}]);
	assign lin_num  = xyzs_pkg::NUM_W'(lin) * xyzs_pkg::NUM_W'(xyzs_pkg::LIN_GAIN)
		+ xyzs_pkg::NUM_W'(xyzs_pkg::LIN_ROUND);

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			seg_s3     <= seg;
			lin_num_s3 <= lin_num;
			e0_s3      <= xyzs_pkg::GAMMA_ROM[{1'b0, idx}];
			diff_s3    <= diff_raw[xyzs_pkg::ROM_W] ? '0 : xyzs_pkg::DIFF_W'(diff_raw);
			t_s3       <= {lin[xyzs_pkg::LIN_W-xyzs_pkg::IDX_BITS-1:0],
				xyzs_pkg::IDX_BITS'(0)};
		end
	end

	// s4: divide by 100 through a reciprocal, interpolate between entries
	assign qprod = xyzs_pkg::QP_W'(lin_num_s3) * xyzs_pkg::QP_W'(xyzs_pkg::DIV_MUL);
	assign iprod = IP_W'(diff_s3) * IP_W'(t_s3) + IP_W'(1 << (xyzs_pkg::LIN_W - 1));

	always_ff @(posedge clk) begin
		if (ctl.adv_s4) begin
			seg_s4    <= seg_s3;
			q_s4      <= qprod[xyzs_pkg::QP_W-1:xyzs_pkg::DIV_SHIFT];
			interp_s4 <= iprod[xyzs_pkg::LIN_W +: xyzs_pkg::DIFF_W];
			e0_s4     <= e0_s3;
		end
	end

	// s5: pick the segment and clamp to [0, 1.0]
	assign v_pow = xyzs_pkg::V_W'(e0_s4) + $signed({2'b00, interp_s4});

	always_comb begin
		vc    = '0;
		v_sel = v_pow;
		unique case (seg_s4)
			xyzs_pkg::SEG_ZERO: vc = '0;
			xyzs_pkg::SEG_SAT:  vc = xyzs_pkg::VC_W'(xyzs_pkg::ONE_Q24);
			xyzs_pkg::SEG_LIN, xyzs_pkg::SEG_POW: begin
				if (seg_s4 == xyzs_pkg::SEG_LIN) begin
					v_sel = xyzs_pkg::V_W'($signed({1'b0, q_s4}));
				end
				if (v_sel <= 0) begin
					vc = '0;
				end else if (v_sel > xyzs_pkg::V_W'(xyzs_pkg::ONE_Q24)) begin
					vc = xyzs_pkg::VC_W'(xyzs_pkg::ONE_Q24);
				end else begin
					vc = xyzs_pkg::VC_W'(v_sel);
				end
			end
			default: vc = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s5) begin
			seg_s5 <= seg_s4;
			vc_s5  <= vc;
		end
	end

	// s6: scale to the output code with rounding
	assign cprod = CP_W'(vc_s5) * CP_W'(xyzs_pkg::MAXC) + CP_W'(1 << (xyzs_pkg::LIN_W - 1));

	always_ff @(posedge clk) begin
		if (ctl.adv_s6) begin
			code_s6 <= (seg_s5 == xyzs_pkg::SEG_ZERO) ? '0
				: cprod[xyzs_pkg::LIN_W +: xyzs_pkg::OUT_BITS];
		end
	end

	assign code = code_s6;

endmodule

@@ src/xyz_to_srgb_converter.sv @@
// Top level of the CIE XYZ (D65) to gamma-encoded sRGB converter.
// Depends on xyzs_pkg, xyzs_if (channel interfaces) and xyzs_encode.

// Converts one XYZ color (three signed 24-bit words, 16 fraction bits) per
// beat into three 12-bit sRGB codes. The block is a six-stage pipeline that
// accepts a new beat on every clock while the result channel is ready;
// throughput is then one beat per cycle, set by the multipliers that
// each own a stage (matrix products, reciprocal divide and interpolation,
// final code scaling). Every stage advances on its own when it is empty or
// its successor advances, so a stalled result beat holds only the stages
// behind it until a bubble is absorbed, and nothing is lost or repeated.
// The 257-entry gamma table is a constant computed at elaboration; there is
// no configuration, no clearing pass and no state beyond the pipeline.
module xyz_to_srgb_converter (
	input  logic clk,
	input  logic arst_n,
	xyzs_xyz_if.sink   xyz,
	xyzs_rgb_if.source rgb
);

	logic signed [xyzs_pkg::IN_W-1:0] xyz_in [3];
	logic signed [xyzs_pkg::ACC_W-1:0] acc [3];
	xyzs_pkg::seg_t seg_nx [3];

	// Stage advance enables, back to front
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	xyzs_pkg::pipe_ctl_t ctl;

	logic signed [xyzs_pkg::PROD_W-1:0] prod_s1 [3][3];
	xyzs_pkg::seg_t                     seg_s2 [3];
	logic [xyzs_pkg::LIN_W-1:0]         lin_s2 [3];
	logic [xyzs_pkg::OUT_BITS-1:0]      code [3];

	assign adv_s6 = !vld_s6 || rgb.ready;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;

	assign xyz.ready = adv_s1;
	assign rgb.valid = vld_s6;

	assign ctl = '{adv_s3: adv_s3, adv_s4: adv_s4, adv_s5: adv_s5, adv_s6: adv_s6};

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= xyz.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
		end
	end

	assign xyz_in[0] = xyz.cie_x;
	assign xyz_in[1] = xyz.cie_y;
	assign xyz_in[2] = xyz.cie_z;

	// s1: the nine matrix products
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[c][k] <= xyzs_pkg::PROD_W'(xyz_in[k])
						* xyzs_pkg::PROD_W'(xyzs_pkg::COEF[c][k]);
				end
			end
		end
	end

	// s2: sum each row, drop to Q24 linear, classify the segment
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = xyzs_pkg::ACC_W'(prod_s1[c][0]) + xyzs_pkg::ACC_W'(prod_s1[c][1])
				+ xyzs_pkg::ACC_W'(prod_s1[c][2]);
			if (acc[c] <= 0) begin
				seg_nx[c] = xyzs_pkg::SEG_ZERO;
			end else if (acc[c][xyzs_pkg::ACC_W-1:xyzs_pkg::LIN_SHIFT+xyzs_pkg::LIN_W] != '0)
			begin
				seg_nx[c] = xyzs_pkg::SEG_SAT;
			end else if (acc[c][xyzs_pkg::LIN_SHIFT +: xyzs_pkg::LIN_W]
				<= xyzs_pkg::LIN_W'(xyzs_pkg::LIN_THRESH)) begin
				seg_nx[c] = xyzs_pkg::SEG_LIN;
			end else begin
				seg_nx[c] = xyzs_pkg::SEG_POW;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int c = 0; c < 3; c++) begin
				seg_s2[c] <= seg_nx[c];
				lin_s2[c] <= acc[c][xyzs_pkg::LIN_SHIFT +: xyzs_pkg::LIN_W];
			end
		end
	end

	// s3..s6: transfer curve, one lane per channel
	for (genvar c = 0; c < 3; c++) begin : g_lane
		xyzs_encode u_encode (
			.clk    (clk),
			.ctl    (ctl),
			.seg    (seg_s2[c]),
			.lin    (lin_s2[c]),
			.code   (code[c])
		);
	end

	assign rgb.red   = code[0];
	assign rgb.green = code[1];
	assign rgb.blue  = code[2];

`ifndef SYNTH
	// A full pipeline with the result stalled must hold off the input
	a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && !rgb.ready)
		|-> !xyz.ready)
		else $error("input taken while the full pipeline is stalled");

	// A result only appears when an item sat in the stage before it
	a_result_from_s5: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rgb.valid) |-> $past(vld_s5))
		else $error("result valid without an item in stage five");

	// Taking the last result with nothing behind it empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rgb.valid && rgb.ready && !vld_s5) |=> !rgb.valid)
		else $error("result repeated after it was taken");
`endif

endmodule

@@ tb/xyzs_tb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the XYZ to sRGB converter testbench: an sRGB code predictor and the
// queue of RGB codes still owed by the block. Depends on xyzs_pkg for port widths.
package xyzs_tb_pkg;

	localparam int CODE_W = xyzs_pkg::OUT_BITS;
	localparam int XYZ_W  = xyzs_pkg::IN_W;

	// Linear value is Q24 after dropping FRAC_BITS-8 bits of the Q32 sum
	localparam int     LIN_SHIFT  = 8;
	localparam longint ONE_Q24    = longint'(1) << 24;
	localparam longint HALF_Q24   = longint'(1) << 23;
	localparam longint LIN_LIMIT  = 52526;
	localparam longint LIN_GAIN   = 1292;
	localparam longint LIN_ROUND  = 50;
	localparam longint LIN_DIV    = 100;

	// Power segment table: 1.055*a^(5/12) - 0.055 in thousandths
	localparam int     GAMMA_DEPTH     = 256;
	localparam int     ROOT_SCALE_BITS = 288;
	localparam longint CURVE_GAIN      = 1055;
	localparam longint CURVE_OFFSET    = 55;
	localparam longint CURVE_HALF      = 500;
	localparam longint CURVE_DIV       = 1000;

	// XYZ to linear RGB in Q16
	localparam int RGB_FROM_XYZ [3][3] = '{
		'{ 212376, -100742, -32676},
		'{ -63498,  122932,   2720},
		'{   3650,  -13369,  69272}
	};

	typedef struct packed {
		logic [CODE_W-1:0] red;
		logic [CODE_W-1:0] green;
		logic [CODE_W-1:0] blue;
	} rgb_code_t;

	class srgb_tracker;
		int        mismatches;
		rgb_code_t pending_rgb [$];
		longint    gamma_q24 [0:GAMMA_DEPTH];

		// Build the table with an exact integer twelfth root per entry
		function new();
			logic [383:0] target;
			logic [383:0] pw;
			longint lo;
			longint hi;
			longint mid;
			longint num;
			mismatches = 0;
			for (int i = 0; i <= GAMMA_DEPTH; i++) begin
				target = 384'(1);
				repeat (5) target = target * 384'(i);
				target = target << ROOT_SCALE_BITS;
				lo = 0;
				hi = ONE_Q24;
				while (lo < hi) begin
					mid = lo + (hi - lo + 1) / 2;
					pw = 384'(1);
					repeat (12) pw = pw * 384'(mid);
					repeat (5) pw = pw * 384'(GAMMA_DEPTH);
					if (pw <= target) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				num = CURVE_GAIN * lo - CURVE_OFFSET * ONE_Q24 + CURVE_HALF;
				if (num >= 0) begin
					gamma_q24[i] = num / CURVE_DIV;
				end else begin
					gamma_q24[i] = -((-num + CURVE_DIV - 1) / CURVE_DIV);
				end
			end
		endfunction

		// Map one matrix sum (Q32) to its clamped sRGB code
		function logic [CODE_W-1:0] gamma_code(longint acc);
			longint maxc;
			longint lin;
			longint p;
			longint idx;
			longint t;
			longint e0;
			longint diff;
			longint v;
			maxc = (longint'(1) << CODE_W) - 1;
			if (acc <= 0) return '0;
			lin = acc >>> LIN_SHIFT;
			if (lin >= ONE_Q24) return CODE_W'(maxc);
			if (lin <= LIN_LIMIT) begin
				v = (lin * LIN_GAIN + LIN_ROUND) / LIN_DIV;
			end else begin
				p = lin * GAMMA_DEPTH;
				idx = p >>> 24;
				t = p & (ONE_Q24 - 1);
				if (idx >= GAMMA_DEPTH) idx = GAMMA_DEPTH - 1;
				e0 = gamma_q24[idx];
				diff = gamma_q24[idx + 1] - e0;
				if (diff < 0) diff = 0;
				v = e0 + ((diff * t + HALF_Q24) >>> 24);
			end
			if (v <= 0) return '0;
			if (v > ONE_Q24) v = ONE_Q24;
			return CODE_W'((v * maxc + HALF_Q24) >>> 24);
		endfunction

		// Queue the codes owed for one accepted XYZ beat
		function void note_xyz(logic signed [XYZ_W-1:0] x, logic signed [XYZ_W-1:0] y,
			logic signed [XYZ_W-1:0] z);
			longint ch [3];
			longint acc;
			logic [CODE_W-1:0] enc [3];
			rgb_code_t code;
			ch[0] = x;
			ch[1] = y;
			ch[2] = z;
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					acc += longint'(RGB_FROM_XYZ[c][k]) * ch[k];
				end
				enc[c] = gamma_code(acc);
			end
			code.red   = enc[0];
			code.green = enc[1];
			code.blue  = enc[2];
			pending_rgb.push_back(code);
		endfunction

		// Compare one accepted RGB beat with the oldest owed codes
		function void check_rgb(rgb_code_t got);
			rgb_code_t want;
			if (pending_rgb.size() == 0) begin
				$error("rgb beat with no pending xyz beat: red %0d green %0d blue %0d",
					got.red, got.green, got.blue);
				mismatches++;
				return;
			end
			want = pending_rgb.pop_front();
			if (got.red !== want.red) begin
				$error("red: expected %0d, got %0d", want.red, got.red);
				mismatches++;
			end
			if (got.green !== want.green) begin
				$error("green: expected %0d, got %0d", want.green, got.green);
				mismatches++;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %0d, got %0d", want.blue, got.blue);
				mismatches++;
			end
		endfunction
	endclass

endpackage

@@ tb/xyz_to_srgb_converter_tb.sv @@
`timescale 1ns / 100ps
// Top of the XYZ to sRGB converter testbench: clock, reset, beat drivers and monitor.
// Depends on xyzs_pkg, the xyzs_if channel interfaces, xyzs_tb_pkg and the block.
module xyz_to_srgb_converter_tb;

	import xyzs_tb_pkg::*;

	localparam int RESET_CYCLES  = 11;
	localparam int CHUNK_ITEMS   = 100;
	localparam int RANDOM_CHUNKS = 8;
	// The pipeline is six stages deep; give stray beats time to show up
	localparam int DRAIN_CYCLES  = 32;
	localparam int CYCLE_LIMIT   = 200000;

	localparam logic signed [XYZ_W-1:0] XYZ_MAX = {1'b0, {(XYZ_W-1){1'b1}}};
	localparam logic signed [XYZ_W-1:0] XYZ_MIN = {1'b1, {(XYZ_W-1){1'b0}}};

	logic clk;
	logic arst_n;

	// Percent chance per cycle that the sender idles / the receiver stalls
	int send_idle_pct;
	int recv_stall_pct;
	int cycle_count;

	srgb_tracker tracker;

	xyzs_xyz_if xyz_ch ();
	xyzs_rgb_if rgb_ch ();

	xyz_to_srgb_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.xyz    (xyz_ch),
		.rgb    (rgb_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: end the run if the block stops delivering
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: hold ready low during reset, then stall at the phase rate.
	// Exactly one assignment per edge, so ready never glitches in a step.
	initial begin
		rgb_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rgb_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: sample the result channel at the edge, before any update lands
	always @(posedge clk) begin
		if (arst_n && rgb_ch.valid && rgb_ch.ready) begin
			tracker.check_rgb({rgb_ch.red, rgb_ch.green, rgb_ch.blue});
		end
	end

	// Offer one XYZ beat and hold it until the block takes it. Idle cycles
	// first, with valid low and junk on the payload so that nothing in the
	// block may look at the fields without valid.
	task automatic send_xyz(input logic signed [XYZ_W-1:0] x, input logic signed [XYZ_W-1:0] y,
		input logic signed [XYZ_W-1:0] z);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			xyz_ch.valid <= 1'b0;
			xyz_ch.cie_x <= XYZ_W'($urandom);
			xyz_ch.cie_y <= XYZ_W'($urandom);
			xyz_ch.cie_z <= XYZ_W'($urandom);
			@(posedge clk);
		end
		xyz_ch.valid <= 1'b1;
		xyz_ch.cie_x <= x;
		xyz_ch.cie_y <= y;
		xyz_ch.cie_z <= z;
		@(posedge clk);
		while (!xyz_ch.ready) @(posedge clk);
		tracker.note_xyz(x, y, z);
	endtask

	// One channel value in the flavor picked for the whole beat
	function automatic logic signed [XYZ_W-1:0] random_channel(input int flavor);
		case (flavor)
			0, 1: return XYZ_W'($urandom);
			2, 3, 4, 5, 6: return XYZ_W'($urandom_range(0, 72000));
			7: return XYZ_W'($urandom_range(0, 300));
			8: return XYZ_W'(int'($urandom_range(0, 140000)) - 70000);
			default: begin
				case ($urandom_range(0, 3))
					0: return XYZ_MAX;
					1: return XYZ_MIN;
					2: return '0;
					default: return XYZ_W'(1 << $urandom_range(0, XYZ_W - 1));
				endcase
			end
		endcase
	endfunction

	task automatic send_random_color();
		int flavor;
		flavor = $urandom_range(0, 9);
		send_xyz(random_channel(flavor), random_channel(flavor), random_channel(flavor));
	endtask

	initial begin
		tracker = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n       <= 1'b0;
		xyz_ch.valid <= 1'b0;
		xyz_ch.cie_x <= '0;
		xyz_ch.cie_y <= '0;
		xyz_ch.cie_z <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats, back to back with no stalls.
		// Field extremes and black.
		send_xyz('0, '0, '0);
		send_xyz(XYZ_MAX, XYZ_MAX, XYZ_MAX);
		send_xyz(XYZ_MIN, XYZ_MIN, XYZ_MIN);
		send_xyz(XYZ_MAX, XYZ_MIN, '0);
		send_xyz(24'sh555555, 24'shAAAAAA, 24'sh555555);
		send_xyz(24'shAAAAAA, 24'sh555555, 24'shAAAAAA);
		send_xyz(1, 1, 1);
		// Red just inside the linear segment, then just past it where the
		// interpolation starts from the negative first table entry
		send_xyz(63, 0, 0);
		send_xyz(64, 0, 0);
		// Blue on either side of the linear threshold
		send_xyz(0, 0, 194);
		send_xyz(0, 0, 195);
		// Red on either side of full scale
		send_xyz(20223, 0, 0);
		send_xyz(20224, 0, 0);
		// Mid power segment, D65 white and an 18 percent gray
		send_xyz(0, 16384, 0);
		send_xyz(62293, 65536, 71362);
		send_xyz(11213, 11796, 12845);
		// One negative channel at a time: mixes saturation, zero and power
		send_xyz(-65536, 0, 0);
		send_xyz(0, -65536, 0);
		send_xyz(0, 0, -65536);
		send_xyz(65536, 65536, 65536);

		// Random beats. Cycle the pressure phases twice: free flow, sender
		// gaps, receiver stalls, then both together.
		for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
			case (chunk % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct  = 35;
					recv_stall_pct = 35;
				end
			endcase
			repeat (CHUNK_ITEMS) send_random_color();
		end

		// Drop valid, let the pipeline drain, then watch for stray beats
		xyz_ch.valid <= 1'b0;
		while (tracker.pending_rgb.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
